### sv/odometry_pose_predict_macros.svh
// Assertion macros used by the odometry pose prediction back end (opp_back).
// No dependencies; expects clk, and for OPP_ASSERT also rst_n, in the scope of each use.
`ifndef ODOMETRY_POSE_PREDICT_MACROS_SVH
`define ODOMETRY_POSE_PREDICT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define OPP_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("odometry pose predict check failed");
`define OPP_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("odometry pose predict check failed");
`else
`define OPP_ASSERT(lbl, prop)
`define OPP_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

### sv/opp_pkg.sv
// Shared types, constants and arithmetic helpers for the pose predictor.
// No dependencies.
`timescale 1ns / 1ps
package opp_pkg;

    typedef logic signed [31:0] word_t;

    localparam logic signed [33:0] PI_Q28      = 34'sd843314857;
    localparam logic signed [33:0] TWO_PI_Q28  = 34'sd1686629713;
    localparam logic signed [33:0] HALF_PI_Q28 = 34'sd421657428;
    localparam word_t              CORDIC_K_Q30 = 32'sd652032874;
    localparam word_t              ONE_Q16      = 32'sd65536;

    localparam int unsigned JOB_QUEUE_DEPTH = 2;

    // result groups
    localparam logic [2:0] GRP_POSE  = 3'd0;
    localparam logic [2:0] GRP_QCOV  = 3'd1;
    localparam logic [2:0] GRP_UCOV  = 3'd2;
    localparam logic [2:0] GRP_FJAC  = 3'd3;
    localparam logic [2:0] GRP_BJAC  = 3'd4;

    // register indexes
    localparam logic [2:0] REG_VAR_POS_X    = 3'd0;
    localparam logic [2:0] REG_VAR_POS_Y    = 3'd1;
    localparam logic [2:0] REG_VAR_HEADING  = 3'd2;
    localparam logic [2:0] REG_VAR_ODO_DIST = 3'd3;
    localparam logic [2:0] REG_VAR_ODO_TURN = 3'd4;

    typedef struct packed {
        word_t pos_x;
        word_t pos_y;
        word_t heading;
        word_t step_dist;
        word_t step_turn;
        word_t noise_x;
        word_t noise_y;
        word_t noise_heading;
    } opp_item_t;

    typedef struct packed {
        opp_item_t item;
        word_t     cos_v;
        word_t     sin_v;
    } opp_job_t;

    typedef struct packed {
        logic [30:0] var_pos_x;
        logic [30:0] var_pos_y;
        logic [30:0] var_heading;
        logic [30:0] var_odo_dist;
        logic [30:0] var_odo_turn;
    } opp_cfg_t;

    function automatic word_t atan_q28(input logic [4:0] i);
        word_t r;
        case (i)
            5'd0:  r = 32'sd210828714;
            5'd1:  r = 32'sd124459457;
            5'd2:  r = 32'sd65760959;
            5'd3:  r = 32'sd33381290;
            5'd4:  r = 32'sd16755422;
            5'd5:  r = 32'sd8385879;
            5'd6:  r = 32'sd4193963;
            5'd7:  r = 32'sd2097109;
            5'd8:  r = 32'sd1048571;
            5'd9:  r = 32'sd524287;
            5'd10: r = 32'sd262144;
            5'd11: r = 32'sd131072;
            5'd12: r = 32'sd65536;
            5'd13: r = 32'sd32768;
            5'd14: r = 32'sd16384;
            5'd15: r = 32'sd8192;
            5'd16: r = 32'sd4096;
            5'd17: r = 32'sd2048;
            5'd18: r = 32'sd1024;
            5'd19: r = 32'sd512;
            5'd20: r = 32'sd256;
            5'd21: r = 32'sd128;
            5'd22: r = 32'sd64;
            5'd23: r = 32'sd32;
            5'd24: r = 32'sd16;
            5'd25: r = 32'sd8;
            5'd26: r = 32'sd4;
            5'd27: r = 32'sd2;
            5'd28: r = 32'sd1;
            default: r = 32'sd0;
        endcase
        return r;
    endfunction

    function automatic word_t sat34(input logic signed [33:0] v);
        word_t r;
        if (v > 34'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (v < -34'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic word_t sat64(input logic signed [63:0] v);
        word_t r;
        if (v > 64'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (v < -64'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

### sv/odometry_pose_predict.sv
// Odometry pose prediction block: one pose/odometry item in, thirteen result
// rows out (pose, Q, U, F, B). Holds the APB register file; depends on opp_pkg.
//
// Each accepted item produces 13 row transfers: predicted pose, the three rows
// of the process noise covariance Q, the input noise covariance U, the state
// Jacobian F and the input Jacobian B (last is high on the 13th). Sine and
// cosine are taken at heading + floor(step_turn/2) with a CORDIC_STEPS long
// rotation, after folding the angle into [-pi/2, pi/2]; yaw itself is not
// wrapped. The back end's single 32x32 multiplier runs 29 product steps plus
// load, drain and handoff; the front end's CORDIC takes one rotation per
// cycle. Rows of one item stream out from a separate buffer while the next
// item is being multiplied, and a two-entry job queue plus an input holding
// register let the input side keep accepting while results wait. Registers
// are to be written only while the block is idle; the block itself does not
// enforce this.
`timescale 1ns / 1ps
module odometry_pose_predict #(
    parameter int CORDIC_STEPS = 24
) (
    input  logic                clk,
    input  logic                rst_n,
    // APB register port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    // input item
    input  logic                in_valid,
    output logic                in_ready,
    input  opp_pkg::word_t      pos_x,
    input  opp_pkg::word_t      pos_y,
    input  opp_pkg::word_t      heading,
    input  opp_pkg::word_t      step_dist,
    input  opp_pkg::word_t      step_turn,
    input  opp_pkg::word_t      noise_x,
    input  opp_pkg::word_t      noise_y,
    input  opp_pkg::word_t      noise_heading,
    // result rows
    output logic                out_valid,
    input  logic                out_ready,
    output logic [2:0]          group,
    output logic [1:0]          row,
    output opp_pkg::word_t      val0,
    output opp_pkg::word_t      val1,
    output opp_pkg::word_t      val2,
    output logic                last
);
    import opp_pkg::*;

    opp_cfg_t   cfg_reg;
    opp_item_t  in_item;
    opp_job_t   fr_job, q_job;
    logic       fr_valid, fr_ready, q_valid, q_ready;
    logic       wr_en;
    logic [2:0] reg_idx;

    // ---- register file: word address picks the register, writes past the
    // last register are dropped, values are kept to 31 bits
    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_VAR_POS_X:    cfg_reg.var_pos_x    <= pwdata[30:0];
                REG_VAR_POS_Y:    cfg_reg.var_pos_y    <= pwdata[30:0];
                REG_VAR_HEADING:  cfg_reg.var_heading  <= pwdata[30:0];
                REG_VAR_ODO_DIST: cfg_reg.var_odo_dist <= pwdata[30:0];
                REG_VAR_ODO_TURN: cfg_reg.var_odo_turn <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_VAR_POS_X:    prdata = {1'b0, cfg_reg.var_pos_x};
            REG_VAR_POS_Y:    prdata = {1'b0, cfg_reg.var_pos_y};
            REG_VAR_HEADING:  prdata = {1'b0, cfg_reg.var_heading};
            REG_VAR_ODO_DIST: prdata = {1'b0, cfg_reg.var_odo_dist};
            REG_VAR_ODO_TURN: prdata = {1'b0, cfg_reg.var_odo_turn};
            default:          prdata = '0;
        endcase
    end

    // ---- input fields gathered into one item
    assign in_item.pos_x         = pos_x;
    assign in_item.pos_y         = pos_y;
    assign in_item.heading       = heading;
    assign in_item.step_dist     = step_dist;
    assign in_item.step_turn     = step_turn;
    assign in_item.noise_x       = noise_x;
    assign in_item.noise_y       = noise_y;
    assign in_item.noise_heading = noise_heading;

    // front: midpoint heading, fold, CORDIC -> job with sin/cos attached
    opp_front #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .job_valid (fr_valid),
        .job_ready (fr_ready),
        .job       (fr_job)
    );

    // queue decouples trig from the multiply sequencer
    opp_fifo u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .in_job    (fr_job),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_job   (q_job)
    );

    // back: products, sums, row emission
    opp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .job_valid (q_valid),
        .job_ready (q_ready),
        .job       (q_job),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .group     (group),
        .row       (row),
        .val0      (val0),
        .val1      (val1),
        .val2      (val2),
        .last      (last)
    );

endmodule

### sv/opp_front.sv
// Front end: input holding register, midpoint heading, range fold and
// iterative CORDIC. Depends on opp_pkg.
`timescale 1ns / 1ps
module opp_front #(
    parameter int CORDIC_STEPS = 24
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  opp_pkg::opp_item_t in_item,
    output logic               job_valid,
    input  logic               job_ready,
    output opp_pkg::opp_job_t  job
);
    import opp_pkg::*;

    localparam int IW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

    typedef enum logic [1:0] {F_IDLE, F_FOLD, F_ROT, F_PUSH} fstate_t;

    fstate_t            state_reg, state_next;
    logic               hold_valid_reg, hold_valid_next;
    logic [IW-1:0]      iter_reg, iter_next;
    opp_item_t          hold_reg, item_reg;
    logic signed [33:0] th_reg;
    word_t              z_reg, cx_reg, cy_reg;
    logic               neg_reg;

    logic               take, accept, iter_last;
    logic signed [33:0] th_raw, th_red, fold_t, fold_z;
    logic               fold_neg;
    word_t              xs, ys, at;

    function automatic logic signed [33:0] reduce(input logic signed [33:0] v);
        logic signed [33:0] r;
        if (v > PI_Q28)
            r = v - TWO_PI_Q28;
        else if (v < -PI_Q28)
            r = v + TWO_PI_Q28;
        else
            r = v;
        return r;
    endfunction

    assign in_ready  = !hold_valid_reg;
    assign accept    = in_valid && in_ready;
    assign take      = (state_reg == F_IDLE) && hold_valid_reg;
    assign iter_last = (iter_reg == IW'(CORDIC_STEPS - 1));

    always_comb
    begin
        th_raw = 34'(hold_reg.heading) + 34'(hold_reg.step_turn >>> 1);
        th_red = reduce(th_raw);
        fold_t = reduce(th_reg);
        fold_neg = 1'b0;
        if (fold_t > HALF_PI_Q28)
        begin
            fold_z   = fold_t - PI_Q28;
            fold_neg = 1'b1;
        end
        else if (fold_t < -HALF_PI_Q28)
        begin
            fold_z   = fold_t + PI_Q28;
            fold_neg = 1'b1;
        end
        else
        begin
            fold_z = fold_t;
        end
        xs = cx_reg >>> iter_reg;
        ys = cy_reg >>> iter_reg;
        at = atan_q28(5'(iter_reg));
    end

    always_comb
    begin
        state_next      = state_reg;
        iter_next       = iter_reg;
        hold_valid_next = hold_valid_reg;
        if (take)
            hold_valid_next = 1'b0;
        if (accept)
            hold_valid_next = 1'b1;
        case (state_reg)
            F_IDLE:
            begin
                if (take)
                    state_next = F_FOLD;
            end
            F_FOLD:
            begin
                iter_next  = '0;
                state_next = F_ROT;
            end
            F_ROT:
            begin
                if (iter_last)
                    state_next = F_PUSH;
                else
                    iter_next = iter_reg + 1'b1;
            end
            F_PUSH:
            begin
                if (job_ready)
                    state_next = F_IDLE;
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= F_IDLE;
            hold_valid_reg <= 1'b0;
            iter_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            hold_valid_reg <= hold_valid_next;
            iter_reg       <= iter_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            hold_reg <= in_item;
        if (take)
        begin
            item_reg <= hold_reg;
            th_reg   <= th_red;
        end
        if (state_reg == F_FOLD)
        begin
            z_reg   <= fold_z[31:0];
            neg_reg <= fold_neg;
            cx_reg  <= CORDIC_K_Q30;
            cy_reg  <= '0;
        end
        else if (state_reg == F_ROT)
        begin
            if (z_reg >= 0)
            begin
                cx_reg <= cx_reg - ys;
                cy_reg <= cy_reg + xs;
                z_reg  <= z_reg - at;
            end
            else
            begin
                cx_reg <= cx_reg + ys;
                cy_reg <= cy_reg - xs;
                z_reg  <= z_reg + at;
            end
        end
    end

    assign job_valid  = (state_reg == F_PUSH);
    assign job.item   = item_reg;
    assign job.cos_v  = neg_reg ? -cx_reg : cx_reg;
    assign job.sin_v  = neg_reg ? -cy_reg : cy_reg;

endmodule

### sv/opp_fifo.sv
// Short job queue between the trig front end and the matrix back end.
// Depends on opp_pkg.
`timescale 1ns / 1ps
module opp_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  opp_pkg::opp_job_t in_job,
    output logic              out_valid,
    input  logic              out_ready,
    output opp_pkg::opp_job_t out_job
);
    import opp_pkg::*;

    localparam int PW = (JOB_QUEUE_DEPTH > 1) ? $clog2(JOB_QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(JOB_QUEUE_DEPTH + 1);

    opp_job_t      mem_reg [JOB_QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          push, pop;

    assign in_ready  = (count_reg != CW'(JOB_QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_job   = mem_reg[rd_ptr_reg];

    function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
        logic [PW-1:0] r;
        if (p == PW'(JOB_QUEUE_DEPTH - 1))
            r = '0;
        else
            r = p + 1'b1;
        return r;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= bump(wr_ptr_reg);
            if (pop)
                rd_ptr_reg <= bump(rd_ptr_reg);
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= in_job;
    end

endmodule

### sv/opp_back.sv
// Back end: shared multiplier sequencer for covariance and Jacobian terms,
// plus the row emitter with its own buffer. Depends on opp_pkg and the macros.
`timescale 1ns / 1ps
`include "odometry_pose_predict_macros.svh"
module opp_back (
    input  logic              clk,
    input  logic              rst_n,
    input  opp_pkg::opp_cfg_t cfg,
    input  logic              job_valid,
    output logic              job_ready,
    input  opp_pkg::opp_job_t job,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [2:0]        group,
    output logic [1:0]        row,
    output opp_pkg::word_t    val0,
    output opp_pkg::word_t    val1,
    output opp_pkg::word_t    val2,
    output logic              last
);
    import opp_pkg::*;

    // product slots, one per sequencer step
    localparam int         NUM_PROD = 29;
    localparam logic [4:0] P_DS  = 5'd0,  P_DC  = 5'd1,  P_DD  = 5'd2,  P_QD  = 5'd3;
    localparam logic [4:0] P_SS  = 5'd4,  P_CC  = 5'd5,  P_SC  = 5'd6,  P_DDS = 5'd7;
    localparam logic [4:0] P_DDC = 5'd8,  P_UQ  = 5'd9,  P_UH  = 5'd10, P_T1  = 5'd11;
    localparam logic [4:0] P_T2  = 5'd12, P_T3  = 5'd13, P_QA  = 5'd14, P_QB  = 5'd15;
    localparam logic [4:0] P_QC  = 5'd16, P_QE  = 5'd17, P_Q23 = 5'd18, P_A1  = 5'd19;
    localparam logic [4:0] P_A2  = 5'd20, P_A3  = 5'd21, P_A4  = 5'd22, P_A5  = 5'd23;
    localparam logic [4:0] P_A6  = 5'd24, P_A7  = 5'd25, P_U23 = 5'd26, P_B1  = 5'd27;
    localparam logic [4:0] P_B2  = 5'd28;
    localparam logic [3:0] ROW_LAST = 4'd12;

    typedef enum logic [1:0] {B_IDLE, B_RUN, B_DRAIN, B_HAND} bstate_t;

    typedef struct packed {
        word_t x, y, yaw;
        word_t q11, q12, q13, q22, q23, qt;
        word_t u11, u12, u13, u22, u23, uy;
        word_t fdx, fdy, jc, jb1, js, jb2;
    } rows_t;

    bstate_t            bstate_reg, bstate_next;
    logic [4:0]         step_reg, step_next;
    logic               wr_valid_reg, wr_valid_next;
    logic               emit_busy_reg, emit_busy_next;
    logic [3:0]         row_cnt_reg, row_cnt_next;

    opp_job_t           job_reg;
    word_t              prod_reg [NUM_PROD];
    logic signed [63:0] mult_reg;
    logic [4:0]         wr_idx_reg;
    logic               wr_q16_reg;
    rows_t              rows_reg;

    word_t              d_v, s_v, c_v, hd_v, qt_v, ud_v, uy_v, vx_v, vy_v;
    word_t              op_a, op_b;
    logic               op_q16;
    logic signed [63:0] mult_next, shifted;
    logic               hand, emit_xfer;
    rows_t              rows_next;

    assign d_v  = job_reg.item.step_dist;
    assign s_v  = job_reg.sin_v;
    assign c_v  = job_reg.cos_v;
    assign hd_v = d_v >>> 1;
    assign qt_v = $signed({1'b0, cfg.var_heading});
    assign ud_v = $signed({1'b0, cfg.var_odo_dist});
    assign uy_v = $signed({1'b0, cfg.var_odo_turn});
    assign vx_v = $signed({1'b0, cfg.var_pos_x});
    assign vy_v = $signed({1'b0, cfg.var_pos_y});

    assign job_ready = (bstate_reg == B_IDLE);
    assign hand      = (bstate_reg == B_HAND) && !emit_busy_reg;
    assign emit_xfer = out_valid && out_ready;

    // step schedule: no step reads the slot written by the step just before it
    always_comb
    begin
        op_a   = d_v;
        op_b   = s_v;
        op_q16 = 1'b0;
        case (step_reg)
            P_DS:  begin op_a = d_v;            op_b = s_v;              end
            P_DC:  begin op_a = d_v;            op_b = c_v;              end
            P_DD:  begin op_a = d_v;            op_b = d_v;  op_q16 = 1'b1; end
            P_QD:  begin op_a = hd_v;           op_b = hd_v; op_q16 = 1'b1; end
            P_SS:  begin op_a = s_v;            op_b = s_v;              end
            P_CC:  begin op_a = c_v;            op_b = c_v;              end
            P_SC:  begin op_a = s_v;            op_b = c_v;              end
            P_DDS: begin op_a = prod_reg[P_DD]; op_b = s_v;              end
            P_DDC: begin op_a = prod_reg[P_DD]; op_b = c_v;              end
            P_UQ:  begin op_a = uy_v; op_b = prod_reg[P_QD]; op_q16 = 1'b1; end
            P_UH:  begin op_a = uy_v;           op_b = hd_v; op_q16 = 1'b1; end
            P_T1:  begin op_a = prod_reg[P_DDS]; op_b = s_v;             end
            P_T2:  begin op_a = prod_reg[P_DDS]; op_b = c_v;             end
            P_T3:  begin op_a = prod_reg[P_DDC]; op_b = c_v;             end
            P_QA:  begin op_a = prod_reg[P_T1]; op_b = qt_v; op_q16 = 1'b1; end
            P_QB:  begin op_a = prod_reg[P_T2]; op_b = qt_v; op_q16 = 1'b1; end
            P_QC:  begin op_a = prod_reg[P_DS]; op_b = qt_v; op_q16 = 1'b1; end
            P_QE:  begin op_a = prod_reg[P_T3]; op_b = qt_v; op_q16 = 1'b1; end
            P_Q23: begin op_a = prod_reg[P_DC]; op_b = qt_v; op_q16 = 1'b1; end
            P_A1:  begin op_a = ud_v;           op_b = prod_reg[P_CC];   end
            P_A2:  begin op_a = prod_reg[P_UQ]; op_b = prod_reg[P_SS];   end
            P_A3:  begin op_a = ud_v;           op_b = prod_reg[P_SC];   end
            P_A4:  begin op_a = prod_reg[P_UQ]; op_b = prod_reg[P_SC];   end
            P_A5:  begin op_a = prod_reg[P_UH]; op_b = s_v;              end
            P_A6:  begin op_a = ud_v;           op_b = prod_reg[P_SS];   end
            P_A7:  begin op_a = prod_reg[P_UQ]; op_b = prod_reg[P_CC];   end
            P_U23: begin op_a = prod_reg[P_UH]; op_b = c_v;              end
            P_B1:  begin op_a = hd_v;           op_b = s_v;              end
            P_B2:  begin op_a = hd_v;           op_b = c_v;              end
            default: begin op_a = d_v;          op_b = s_v;              end
        endcase
        mult_next = 64'(op_a) * 64'(op_b);
        shifted   = wr_q16_reg ? (mult_reg >>> 16) : (mult_reg >>> 30);
    end

    // final row values, formed once the last product has landed
    always_comb
    begin
        rows_next.x   = sat34(34'(job_reg.item.pos_x) + 34'(prod_reg[P_DC])
                              + 34'(job_reg.item.noise_x));
        rows_next.y   = sat34(34'(job_reg.item.pos_y) + 34'(prod_reg[P_DS])
                              + 34'(job_reg.item.noise_y));
        rows_next.yaw = sat34(34'(job_reg.item.heading) + 34'(job_reg.item.step_turn)
                              + 34'(job_reg.item.noise_heading));
        rows_next.q11 = sat34(34'(vx_v) + 34'(prod_reg[P_QA]));
        rows_next.q12 = sat34(-34'(prod_reg[P_QB]));
        rows_next.q13 = sat34(-34'(prod_reg[P_QC]));
        rows_next.q22 = sat34(34'(vy_v) + 34'(prod_reg[P_QE]));
        rows_next.q23 = prod_reg[P_Q23];
        rows_next.qt  = qt_v;
        rows_next.u11 = sat34(34'(prod_reg[P_A1]) + 34'(prod_reg[P_A2]));
        rows_next.u12 = sat34(34'(prod_reg[P_A3]) - 34'(prod_reg[P_A4]));
        rows_next.u13 = sat34(-34'(prod_reg[P_A5]));
        rows_next.u22 = sat34(34'(prod_reg[P_A6]) + 34'(prod_reg[P_A7]));
        rows_next.u23 = prod_reg[P_U23];
        rows_next.uy  = uy_v;
        rows_next.fdx = sat34(-34'(prod_reg[P_DS]));
        rows_next.fdy = prod_reg[P_DC];
        rows_next.jc  = c_v >>> 14;
        rows_next.jb1 = sat34(-34'(prod_reg[P_B1]));
        rows_next.js  = s_v >>> 14;
        rows_next.jb2 = prod_reg[P_B2];
    end

    always_comb
    begin
        bstate_next    = bstate_reg;
        step_next      = step_reg;
        wr_valid_next  = 1'b0;
        emit_busy_next = emit_busy_reg;
        row_cnt_next   = row_cnt_reg;
        case (bstate_reg)
            B_IDLE:
            begin
                if (job_valid)
                begin
                    step_next   = '0;
                    bstate_next = B_RUN;
                end
            end
            B_RUN:
            begin
                wr_valid_next = 1'b1;
                if (step_reg == P_B2)
                    bstate_next = B_DRAIN;
                else
                    step_next = step_reg + 1'b1;
            end
            B_DRAIN: bstate_next = B_HAND;
            B_HAND:
            begin
                if (hand)
                    bstate_next = B_IDLE;
            end
            default: bstate_next = B_IDLE;
        endcase
        if (hand)
        begin
            emit_busy_next = 1'b1;
            row_cnt_next   = '0;
        end
        else if (emit_xfer)
        begin
            if (row_cnt_reg == ROW_LAST)
                emit_busy_next = 1'b0;
            else
                row_cnt_next = row_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bstate_reg    <= B_IDLE;
            step_reg      <= '0;
            wr_valid_reg  <= 1'b0;
            emit_busy_reg <= 1'b0;
            row_cnt_reg   <= '0;
        end
        else
        begin
            bstate_reg    <= bstate_next;
            step_reg      <= step_next;
            wr_valid_reg  <= wr_valid_next;
            emit_busy_reg <= emit_busy_next;
            row_cnt_reg   <= row_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_valid && job_ready)
            job_reg <= job;
        if (bstate_reg == B_RUN)
        begin
            mult_reg   <= mult_next;
            wr_idx_reg <= step_reg;
            wr_q16_reg <= op_q16;
        end
        if (wr_valid_reg)
            prod_reg[wr_idx_reg] <= sat64(shifted);
        if (hand)
            rows_reg <= rows_next;
    end

    always_comb
    begin
        group = GRP_POSE;
        row   = 2'd0;
        val0  = rows_reg.x;
        val1  = rows_reg.y;
        val2  = rows_reg.yaw;
        case (row_cnt_reg)
            4'd0:  begin group = GRP_POSE; row = 2'd0;
                         val0 = rows_reg.x;   val1 = rows_reg.y;   val2 = rows_reg.yaw; end
            4'd1:  begin group = GRP_QCOV; row = 2'd0;
                         val0 = rows_reg.q11; val1 = rows_reg.q12; val2 = rows_reg.q13; end
            4'd2:  begin group = GRP_QCOV; row = 2'd1;
                         val0 = rows_reg.q12; val1 = rows_reg.q22; val2 = rows_reg.q23; end
            4'd3:  begin group = GRP_QCOV; row = 2'd2;
                         val0 = rows_reg.q13; val1 = rows_reg.q23; val2 = rows_reg.qt;  end
            4'd4:  begin group = GRP_UCOV; row = 2'd0;
                         val0 = rows_reg.u11; val1 = rows_reg.u12; val2 = rows_reg.u13; end
            4'd5:  begin group = GRP_UCOV; row = 2'd1;
                         val0 = rows_reg.u12; val1 = rows_reg.u22; val2 = rows_reg.u23; end
            4'd6:  begin group = GRP_UCOV; row = 2'd2;
                         val0 = rows_reg.u13; val1 = rows_reg.u23; val2 = rows_reg.uy;  end
            4'd7:  begin group = GRP_FJAC; row = 2'd0;
                         val0 = ONE_Q16;      val1 = '0;           val2 = rows_reg.fdx; end
            4'd8:  begin group = GRP_FJAC; row = 2'd1;
                         val0 = '0;           val1 = ONE_Q16;      val2 = rows_reg.fdy; end
            4'd9:  begin group = GRP_FJAC; row = 2'd2;
                         val0 = '0;           val1 = '0;           val2 = ONE_Q16;      end
            4'd10: begin group = GRP_BJAC; row = 2'd0;
                         val0 = rows_reg.jc;  val1 = rows_reg.jb1; val2 = '0;           end
            4'd11: begin group = GRP_BJAC; row = 2'd1;
                         val0 = rows_reg.js;  val1 = rows_reg.jb2; val2 = '0;           end
            4'd12: begin group = GRP_BJAC; row = 2'd2;
                         val0 = '0;           val1 = ONE_Q16;      val2 = '0;           end
            default: begin group = GRP_POSE; row = 2'd0;
                         val0 = '0;           val1 = '0;           val2 = '0;           end
        endcase
    end

    assign out_valid = emit_busy_reg;
    assign last      = (row_cnt_reg == ROW_LAST);

    `OPP_ASSERT(a_row_in_range, emit_busy_reg |-> (row_cnt_reg <= ROW_LAST))
    `OPP_ASSERT(a_hand_starts_rows, hand |=> (emit_busy_reg && row_cnt_reg == 4'd0))
    `OPP_ASSERT(a_take_no_write, (job_valid && job_ready) |-> !wr_valid_reg)

endmodule

### sim/tb.sv
// Self-checking testbench for odometry_pose_predict: directed and random pose
// items, APB register sweeps, random idling and a long output stall.
// Depends on opp_pkg and the odometry_pose_predict RTL.
`timescale 1ns / 1ps
module tb;
    import opp_pkg::*;

    // row as the block should present it
    typedef struct {
        logic [2:0]  grp;
        logic [1:0]  rw;
        word_t       v0;
        word_t       v1;
        word_t       v2;
        logic        lst;
    } pose_row_t;

    localparam int STEPS = 24;

    logic        clk;
    logic        rst_n;
    logic        psel, penable, pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid, in_ready;
    word_t       pos_x, pos_y, heading, step_dist, step_turn;
    word_t       noise_x, noise_y, noise_heading;
    logic        out_valid, out_ready;
    logic [2:0]  group;
    logic [1:0]  row;
    word_t       val0, val1, val2;
    logic        last;

    odometry_pose_predict #(.CORDIC_STEPS(STEPS)) dut (.*);

    // shadow of the variance registers
    longint cfg_var[5];

    pose_row_t rows_due[$];
    int        mismatches;
    int        hold_cnt;     // output stall forced by the pressure test
    bit        no_idle;      // both sides run flat out when set

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ---------------------------------------------------------------
    // fixed point helpers
    // ---------------------------------------------------------------
    function automatic longint sat(input longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint mul16(input longint a, input longint b);
        return sat((a * b) >>> 16);
    endfunction

    function automatic longint mul30(input longint a, input longint b);
        return sat((a * b) >>> 30);
    endfunction

    function automatic longint atan_step(input int i);
        longint tab[30] = '{210828714, 124459457, 65760959, 33381290, 16755422,
            8385879, 4193963, 2097109, 1048571, 524287, 262144, 131072, 65536,
            32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16,
            8, 4, 2, 1, 0};
        return tab[i];
    endfunction

    function automatic void push_row(input int k, input int g, input int r,
                                     input longint a, input longint b,
                                     input longint c);
        pose_row_t e;
        e.grp = g[2:0];
        e.rw  = r[1:0];
        e.v0  = a[31:0];
        e.v1  = b[31:0];
        e.v2  = c[31:0];
        e.lst = (k == 12);
        rows_due.push_back(e);
    endfunction

    // Expected 13 rows for one accepted item, under the current registers.
    function automatic void predict_rows(input opp_item_t it);
        longint px, py, h0, d, tn, nx, ny, nh;
        longint th, cx, cy, z, xs, ys, c, s;
        longint ds, dc, dd, hd, qd, qT, uD, uY, ss, cc, sc, dds, ddc;
        longint q11, q12, q13, q22, q23, uq, uh, u11, u12, u13, u22, u23;
        bit     flip;
        px = it.pos_x; py = it.pos_y; h0 = it.heading;
        d = it.step_dist; tn = it.step_turn;
        nx = it.noise_x; ny = it.noise_y; nh = it.noise_heading;
        flip = 0;
        // midpoint heading folded into [-pi/2, pi/2]
        th = h0 + (tn >>> 1);
        while (th > PI_Q28) th -= TWO_PI_Q28;
        while (th < -PI_Q28) th += TWO_PI_Q28;
        if (th > HALF_PI_Q28)
        begin
            th -= PI_Q28; flip = 1;
        end
        else if (th < -HALF_PI_Q28)
        begin
            th += PI_Q28; flip = 1;
        end
        cx = CORDIC_K_Q30; cy = 0; z = th;
        for (int i = 0; i < STEPS && i < 30; i++)
        begin
            xs = cx >>> i;
            ys = cy >>> i;
            if (z >= 0)
            begin
                cx -= ys; cy += xs; z -= atan_step(i);
            end
            else
            begin
                cx += ys; cy -= xs; z += atan_step(i);
            end
        end
        c = flip ? -cx : cx;
        s = flip ? -cy : cy;

        ds = mul30(d, s); dc = mul30(d, c);
        dd = mul16(d, d);
        hd = d >>> 1;
        qd = mul16(hd, hd);
        qT = cfg_var[REG_VAR_HEADING];
        uD = cfg_var[REG_VAR_ODO_DIST];
        uY = cfg_var[REG_VAR_ODO_TURN];
        ss = (s * s) >>> 30; cc = (c * c) >>> 30; sc = (s * c) >>> 30;
        dds = mul30(dd, s); ddc = mul30(dd, c);

        push_row(0, GRP_POSE, 0, sat(px + dc + nx), sat(py + ds + ny),
                 sat(h0 + tn + nh));

        q11 = sat(cfg_var[REG_VAR_POS_X] + mul16(mul30(dds, s), qT));
        q12 = sat(-mul16(mul30(dds, c), qT));
        q13 = sat(-mul16(ds, qT));
        q22 = sat(cfg_var[REG_VAR_POS_Y] + mul16(mul30(ddc, c), qT));
        q23 = mul16(dc, qT);
        push_row(1, GRP_QCOV, 0, q11, q12, q13);
        push_row(2, GRP_QCOV, 1, q12, q22, q23);
        push_row(3, GRP_QCOV, 2, q13, q23, qT);

        uq = mul16(uY, qd);
        uh = mul16(uY, hd);
        u11 = sat(mul30(uD, cc) + mul30(uq, ss));
        u12 = sat(mul30(uD, sc) - mul30(uq, sc));
        u13 = sat(-mul30(uh, s));
        u22 = sat(mul30(uD, ss) + mul30(uq, cc));
        u23 = mul30(uh, c);
        push_row(4, GRP_UCOV, 0, u11, u12, u13);
        push_row(5, GRP_UCOV, 1, u12, u22, u23);
        push_row(6, GRP_UCOV, 2, u13, u23, uY);

        push_row(7, GRP_FJAC, 0, ONE_Q16, 0, sat(-ds));
        push_row(8, GRP_FJAC, 1, 0, ONE_Q16, dc);
        push_row(9, GRP_FJAC, 2, 0, 0, ONE_Q16);

        push_row(10, GRP_BJAC, 0, c >>> 14, sat(-mul30(hd, s)), 0);
        push_row(11, GRP_BJAC, 1, s >>> 14, mul30(hd, c), 0);
        push_row(12, GRP_BJAC, 2, 0, ONE_Q16, 0);
    endfunction

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------
    // mostly short gaps, now and then a long one
    function automatic int idle_len();
        if (no_idle)
            return 0;
        if ($urandom_range(0, 15) == 0)
            return $urandom_range(15, 60);
        if ($urandom_range(0, 2) == 0)
            return $urandom_range(1, 4);
        return 0;
    endfunction

    // Offer one item; returns at the falling edge after its transfer.
    task automatic send_item(input opp_item_t it);
        int g;
        g = idle_len();
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(negedge clk);
        end
        {pos_x, pos_y, heading, step_dist, step_turn, noise_x, noise_y,
         noise_heading} <= it;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        predict_rows(it);
        @(negedge clk);
    endtask

    task automatic stop_input();
        in_valid <= 1'b0;
    endtask

    // Wait until every expected row is back, plus the pipeline latency.
    task automatic drain();
        stop_input();
        while (rows_due.size() != 0)
            @(negedge clk);
        repeat (STEPS + 80) @(negedge clk);
    endtask

    // setup, access, then an idle phase with psel low, so back-to-back writes never
    // drive the bus twice at the same falling edge
    task automatic reg_write(input int idx, input logic [31:0] v);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= 5'(idx * 4); pwdata <= v;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (idx < 5)
            cfg_var[idx] = longint'(v & 32'h7FFF_FFFF);
        @(negedge clk);
    endtask

    task automatic set_all_vars(input logic [31:0] a, input logic [31:0] b,
                                input logic [31:0] c, input logic [31:0] d,
                                input logic [31:0] e);
        reg_write(REG_VAR_POS_X, a);
        reg_write(REG_VAR_POS_Y, b);
        reg_write(REG_VAR_HEADING, c);
        reg_write(REG_VAR_ODO_DIST, d);
        reg_write(REG_VAR_ODO_TURN, e);
    endtask

    function automatic word_t edge_word();
        case ($urandom_range(0, 5))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return 32'sd0;
            3: return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // plausible motion: moderate distances, angles within about +-4 rad
    function automatic opp_item_t sane_item();
        opp_item_t it;
        it.pos_x         = $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
        it.pos_y         = $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
        it.heading       = $urandom_range(0, 32'h7FFF_FFFF) - 32'h4000_0000;
        it.step_dist     = $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
        it.step_turn     = $urandom_range(0, 32'h3FFF_FFFF) - 32'h2000_0000;
        it.noise_x       = $urandom_range(0, 32'h3FFF) - 32'h2000;
        it.noise_y       = $urandom_range(0, 32'h3FFF) - 32'h2000;
        it.noise_heading = $urandom_range(0, 32'h3FFFF) - 32'h20000;
        return it;
    endfunction

    function automatic opp_item_t wild_item();
        opp_item_t it;
        it.pos_x = edge_word(); it.pos_y = edge_word();
        it.heading = edge_word(); it.step_dist = edge_word();
        it.step_turn = edge_word(); it.noise_x = edge_word();
        it.noise_y = edge_word(); it.noise_heading = edge_word();
        return it;
    endfunction

    function automatic opp_item_t mk(input word_t px, input word_t h,
                                     input word_t d, input word_t t);
        opp_item_t it;
        it = '0;
        it.pos_x = px; it.pos_y = -px; it.heading = h;
        it.step_dist = d; it.step_turn = t;
        it.noise_x = 32'sd7; it.noise_y = -32'sd3; it.noise_heading = 32'sd11;
        return it;
    endfunction

    // ---------------------------------------------------------------
    // output side: ready pattern and row checker
    // ---------------------------------------------------------------
    initial
    begin
        int stall_left;
        stall_left = 0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                out_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    stall_left = idle_len();
            end
        end
    end

    always @(posedge clk)
    begin
        pose_row_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (rows_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected row transfer: group %0d row %0d", group, row);
            end
            else
            begin
                e = rows_due.pop_front();
                if (group !== e.grp || row !== e.rw || val0 !== e.v0 ||
                    val1 !== e.v1 || val2 !== e.v2 || last !== e.lst)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("row mismatch: exp g%0d r%0d %h %h %h l%0d, got g%0d r%0d %h %h %h l%0d",
                                 e.grp, e.rw, e.v0, e.v1, e.v2, e.lst,
                                 group, row, val0, val1, val2, last);
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------
    // zero variances after reset; field extremes and angle folding cases
    task automatic test_directed();
        send_item('0);
        send_item(mk(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
        send_item(mk(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000));
        send_item(mk(32'sh1_0000, 32'sd421657428, 32'sh1_0000, 32'sd0));   // +pi/2
        send_item(mk(32'sh1_0000, 32'sd421657429, 32'sh1_0000, 32'sd0));   // past +pi/2
        send_item(mk(32'sh1_0000, -32'sd421657429, 32'sh1_0000, 32'sd0));  // past -pi/2
        send_item(mk(32'sh1_0000, 32'sd843314858, 32'sh2_0000, 32'sd0));   // past +pi
        send_item(mk(32'sh1_0000, -32'sd843314858, 32'sh2_0000, 32'sd0));  // past -pi
        send_item(mk(32'sh1_0000, 32'sd0, 32'sh3_0000, -32'sd1));          // odd negative turn
        send_item(mk(32'sh1_0000, 32'sd0, -32'sd1, 32'sd3));               // odd turn, tiny d
        send_item(mk(32'sh7FFF_0000, 32'sd0, 32'sh7FFF_0000, 32'sd0));     // pose x saturates
        drain();
    endtask

    // covariance rows across register extremes, masking and dead addresses
    task automatic test_registers();
        opp_item_t it;
        set_all_vars(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                     32'h7FFF_FFFF, 32'hFFFF_FFFF);
        reg_write(5, 32'h1234_5678);   // no register there
        reg_write(7, 32'hFFFF_FFFF);
        for (int i = 0; i < 8; i++)
            send_item(i < 4 ? wild_item() : sane_item());
        it = mk(32'sh7FFF_FFFF, 32'sd0, 32'sh7FFF_FFFF, 32'sd0);
        send_item(it);
        drain();
        set_all_vars(32'h0000_0001, 32'h0001_0000, 32'h0000_4000,
                     32'h0000_0100, 32'h0002_0000);
        for (int i = 0; i < 6; i++)
            send_item(sane_item());
        drain();
    endtask

    task automatic test_random(input int n);
        for (int k = 0; k < 4; k++)
        begin
            set_all_vars($urandom, $urandom_range(0, 32'h000F_FFFF), $urandom,
                         $urandom_range(0, 32'h0003_FFFF), $urandom);
            no_idle = (k == 2);
            for (int i = 0; i < n / 4; i++)
                send_item($urandom_range(0, 3) == 0 ? wild_item() : sane_item());
            drain();
            no_idle = 0;
        end
    endtask

    // output held off while input keeps offering; block must stall input
    task automatic test_output_stall();
        set_all_vars(32'h0000_8000, 32'h0000_8000, 32'h0001_0000,
                     32'h0000_2000, 32'h0000_1000);
        no_idle = 1;
        hold_cnt = 600;
        for (int i = 0; i < 12; i++)
            send_item(sane_item());
        drain();
        no_idle = 0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        in_valid = 1'b0;
        pos_x = '0; pos_y = '0; heading = '0; step_dist = '0; step_turn = '0;
        noise_x = '0; noise_y = '0; noise_heading = '0;
        mismatches = 0; hold_cnt = 0; no_idle = 0;
        for (int i = 0; i < 5; i++)
            cfg_var[i] = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (3) @(negedge clk);

        test_directed();
        test_registers();
        test_output_stall();
        test_random(380);

        if (mismatches == 0 && rows_due.size() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("tb failed");
        $finish;
    end

endmodule

### filelist.f
+incdir+sv
sv/opp_pkg.sv
sv/opp_front.sv
sv/opp_fifo.sv
sv/opp_back.sv
sv/odometry_pose_predict.sv
sim/tb.sv
